// ----- rtl/chm_pkg.sv -----
// Package for the chained hash map engine: payload structs, opcodes, states,
// register indexes and default parameter values.
// No dependencies; the engine and the testbench refer to it by scoped names.
package chm_pkg;

  localparam int MIN_HASH_BITS     = 6;
  localparam int MAX_HASH_BITS_DEF = 10;
  localparam int CHAIN_DEPTH_DEF   = 4;
  localparam int ITEM_BITS_DEF     = 32;

  localparam int KEY_W      = 64;
  localparam int ITEM_IO_W  = 32;
  localparam int OP_W       = 3;
  localparam int COUNT_W    = 13;
  localparam int COLL_W     = 11;
  localparam int HBITS_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [63:0]        DEF_MULT      = 64'd11400714819323198485;
  localparam logic [HBITS_W-1:0] DEF_HASH_BITS = 4'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MULT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HBITS = 1'b1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd2;
  localparam logic [OP_W-1:0] OP_REPLACE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]      opcode;
    logic [KEY_W-1:0]     key;
    logic [ITEM_IO_W-1:0] item_in;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic [ITEM_IO_W-1:0] item_out;
    logic                 status;
    logic [COUNT_W-1:0]   item_count;
    logic [COLL_W-1:0]    collision_count;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_HASH,
    ST_RDB,
    ST_CHKB,
    ST_SCAN,
    ST_SCHK,
    ST_ACT,
    ST_PRD,
    ST_PWR,
    ST_SHIFT,
    ST_SWR,
    ST_ADD
  } state_t;

  // The final two steps have their own enum, held in a separate register.
  typedef enum logic [1:0] {
    TL_NONE,
    TL_FIN,
    TL_DONE
  } tail_t;

endpackage

// ----- rtl/chm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/chained_hash_map_engine.sv -----
// Top level of the chained hash map engine.
// Depends on chm_pkg (types, codes, defaults) and chm_ram (bucket storage).

// A transaction is accepted when start is high and busy is low; busy stays
// high until the single result has been shown on out_data with out_valid for
// exactly one cycle, which the receiver must take as it comes. An operation
// runs through the three multiplier passes, the bucket extraction, the
// bucket read and check, a scan of the chain entry by entry when the main
// slot does not decide it, the action, the status write and the result. An
// insert adds a step placing the entry. A removal that touches the chain
// closes it, moving each later chain entry down one place, after promoting
// chain entry 0 into the main slot when the key was in the main slot.
// The pace is set by the shared 32x32 multiplier (three passes build the
// 64-bit hash product) and by the one read port of the chain memory, which
// visits the chain entries one at a time. A clear-all operation and the reset
// both sweep the bucket status memory, one bucket per cycle, over all
// 2**MAX_HASH_BITS buckets (1024 by default); after reset busy stays high for
// that sweep. Unused opcodes return a result with found, item_out and status
// at zero in the cycle right after acceptance.
module chained_hash_map_engine #(
  parameter int MAX_HASH_BITS = chm_pkg::MAX_HASH_BITS_DEF,
  parameter int CHAIN_DEPTH   = chm_pkg::CHAIN_DEPTH_DEF,
  parameter int ITEM_BITS     = chm_pkg::ITEM_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  chm_pkg::in_t                     in_data,
  output logic                             out_valid,
  output chm_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [chm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [chm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int BUCKETS = 1 << MAX_HASH_BITS;
  localparam int LEN_W   = $clog2(CHAIN_DEPTH + 1);
  localparam int IDX_W   = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int CADDR_W = MAX_HASH_BITS + IDX_W;
  localparam int ENTRY_W = chm_pkg::KEY_W + ITEM_BITS;
  localparam int META_W  = 1 + LEN_W;

  // Configuration registers.
  logic [63:0]                   mult_r;
  logic [chm_pkg::HBITS_W-1:0]   hbits_r;

  // Sequencer state.
  chm_pkg::state_t state_r, state_nxt;
  chm_pkg::tail_t  tail_r, tail_nxt;
  logic [MAX_HASH_BITS-1:0] clr_r, clr_nxt;
  logic clr_report_r, clr_report_nxt;
  logic [chm_pkg::COUNT_W-1:0] ent_r, ent_nxt;
  logic [chm_pkg::COLL_W-1:0]  chained_r, chained_nxt;

  // Per-operation working registers.
  logic [chm_pkg::OP_W-1:0]  op_r, op_nxt;
  logic [63:0]               key_r, key_nxt;
  logic [ITEM_BITS-1:0]      item_r, item_nxt;
  logic [63:0]               acc_r, acc_nxt;
  logic [MAX_HASH_BITS-1:0]  bucket_r, bucket_nxt;
  logic                      used_r, used_nxt;
  logic [LEN_W-1:0]          len_r, len_nxt;
  logic [LEN_W-1:0]          idx_r, idx_nxt;
  logic [63:0]               mkey_r, mkey_nxt;
  logic [ITEM_BITS-1:0]      mitem_r, mitem_nxt;
  logic [63:0]               ckey_r, ckey_nxt;
  logic [ITEM_BITS-1:0]      citem_r, citem_nxt;
  logic                      found_r, found_nxt;
  logic                      pos_main_r, pos_main_nxt;
  logic [chm_pkg::ITEM_IO_W-1:0] item_out_r, item_out_nxt;
  logic                      status_r, status_nxt;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // Memory ports.
  logic                     meta_we;
  logic [MAX_HASH_BITS-1:0] meta_waddr;
  logic [META_W-1:0]        meta_wdata, meta_rdata;
  logic                     main_we;
  logic [ENTRY_W-1:0]       main_wdata, main_rdata;
  logic                     chain_we;
  logic [CADDR_W-1:0]       chain_waddr, chain_raddr;
  logic [ENTRY_W-1:0]       chain_wdata, chain_rdata;
  logic [IDX_W-1:0]         chain_widx, chain_ridx;

  // Hash width clamp and bucket extraction.
  logic [4:0]               hb_in, hb_eff, hb_shift;
  logic [MAX_HASH_BITS-1:0] hash_top;
  logic [63:0]              item_in64;
  logic [63:0]              found_item64;

  assign hb_in    = {1'b0, hbits_r};
  assign hb_eff   = (hb_in < 5'(chm_pkg::MIN_HASH_BITS)) ? 5'(chm_pkg::MIN_HASH_BITS) :
                    (hb_in > 5'(MAX_HASH_BITS)) ? 5'(MAX_HASH_BITS) : hb_in;
  assign hb_shift = 5'(MAX_HASH_BITS) - hb_eff;
  assign hash_top = acc_r[63 -: MAX_HASH_BITS];

  assign item_in64    = {32'd0, in_data.item_in};
  assign found_item64 = pos_main_r ? 64'(mitem_r) : 64'(citem_r);

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign chain_waddr = {bucket_r, chain_widx};
  assign chain_raddr = {bucket_r, chain_ridx};

  chm_ram #(.WIDTH(META_W), .DEPTH(BUCKETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (bucket_r),
    .rdata (meta_rdata)
  );

  chm_ram #(.WIDTH(ENTRY_W), .DEPTH(BUCKETS)) u_main_ram (
    .clk   (clk),
    .we    (main_we),
    .waddr (bucket_r),
    .wdata (main_wdata),
    .raddr (bucket_r),
    .rdata (main_rdata)
  );

  chm_ram #(.WIDTH(ENTRY_W), .DEPTH(BUCKETS << IDX_W)) u_chain_ram (
    .clk   (clk),
    .we    (chain_we),
    .waddr (chain_waddr),
    .wdata (chain_wdata),
    .raddr (chain_raddr),
    .rdata (chain_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r  <= chm_pkg::DEF_MULT;
      hbits_r <= chm_pkg::DEF_HASH_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chm_pkg::CFG_MULT:  mult_r  <= cfg_wdata;
        chm_pkg::CFG_HBITS: hbits_r <= cfg_wdata[chm_pkg::HBITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= chm_pkg::ST_CLEAR;
      tail_r       <= chm_pkg::TL_NONE;
      clr_r        <= '0;
      clr_report_r <= 1'b0;
      ent_r        <= '0;
      chained_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      tail_r       <= tail_nxt;
      clr_r        <= clr_nxt;
      clr_report_r <= clr_report_nxt;
      ent_r        <= ent_nxt;
      chained_r    <= chained_nxt;
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    item_r     <= item_nxt;
    acc_r      <= acc_nxt;
    bucket_r   <= bucket_nxt;
    used_r     <= used_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    mkey_r     <= mkey_nxt;
    mitem_r    <= mitem_nxt;
    ckey_r     <= ckey_nxt;
    citem_r    <= citem_nxt;
    found_r    <= found_nxt;
    pos_main_r <= pos_main_nxt;
    item_out_r <= item_out_nxt;
    status_r   <= status_nxt;
  end

  // Sequencer: the tail steps (final status write and result cycle) are held
  // in tail_r so that the main state enum stays at sixteen members.
  always_comb begin
    state_nxt      = state_r;
    tail_nxt       = tail_r;
    clr_nxt        = clr_r;
    clr_report_nxt = clr_report_r;
    ent_nxt        = ent_r;
    chained_nxt    = chained_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    item_nxt       = item_r;
    acc_nxt        = acc_r;
    bucket_nxt     = bucket_r;
    used_nxt       = used_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    mkey_nxt       = mkey_r;
    mitem_nxt      = mitem_r;
    ckey_nxt       = ckey_r;
    citem_nxt      = citem_r;
    found_nxt      = found_r;
    pos_main_nxt   = pos_main_r;
    item_out_nxt   = item_out_r;
    status_nxt     = status_r;

    mul_a       = key_r[31:0];
    mul_b       = mult_r[31:0];
    meta_we     = 1'b0;
    meta_waddr  = bucket_r;
    meta_wdata  = {used_r, len_r};
    main_we     = 1'b0;
    main_wdata  = {key_r, item_r};
    chain_we    = 1'b0;
    chain_widx  = idx_r[IDX_W-1:0];
    chain_wdata = {key_r, item_r};
    chain_ridx  = idx_r[IDX_W-1:0];

    if (tail_r == chm_pkg::TL_FIN) begin
      // Commit the bucket status kept in registers during the operation.
      meta_we  = 1'b1;
      tail_nxt = chm_pkg::TL_DONE;
    end else if (tail_r == chm_pkg::TL_DONE) begin
      tail_nxt       = chm_pkg::TL_NONE;
      state_nxt      = chm_pkg::ST_IDLE;
      clr_report_nxt = 1'b0;
    end else begin
      unique case (state_r)
        chm_pkg::ST_CLEAR: begin
          meta_we    = 1'b1;
          meta_waddr = clr_r;
          meta_wdata = '0;
          clr_nxt    = clr_r + 1'b1;
          if (clr_r == '1) begin
            if (clr_report_r) begin
              tail_nxt = chm_pkg::TL_DONE;
            end else begin
              state_nxt = chm_pkg::ST_IDLE;
            end
          end
        end
        chm_pkg::ST_IDLE: begin
          if (start) begin
            op_nxt       = in_data.opcode;
            key_nxt      = in_data.key;
            item_nxt     = item_in64[ITEM_BITS-1:0];
            found_nxt    = 1'b0;
            item_out_nxt = '0;
            status_nxt   = 1'b0;
            if (in_data.opcode == chm_pkg::OP_CLEAR) begin
              ent_nxt        = '0;
              chained_nxt    = '0;
              clr_report_nxt = 1'b1;
              clr_nxt        = '0;
              state_nxt      = chm_pkg::ST_CLEAR;
            end else if (in_data.opcode > chm_pkg::OP_REPLACE) begin
              tail_nxt  = chm_pkg::TL_DONE;
              state_nxt = chm_pkg::ST_ADD;
            end else begin
              state_nxt = chm_pkg::ST_MUL0;
            end
          end
        end
        // Product mod 2**64 = kl*ml + ((kh*ml + kl*mh) << 32).
        chm_pkg::ST_MUL0: begin
          acc_nxt   = mul_p;
          state_nxt = chm_pkg::ST_MUL1;
        end
        chm_pkg::ST_MUL1: begin
          mul_a     = key_r[63:32];
          acc_nxt   = {acc_r[63:32] + mul_p[31:0], acc_r[31:0]};
          state_nxt = chm_pkg::ST_MUL2;
        end
        chm_pkg::ST_MUL2: begin
          mul_b     = mult_r[63:32];
          acc_nxt   = {acc_r[63:32] + mul_p[31:0], acc_r[31:0]};
          state_nxt = chm_pkg::ST_HASH;
        end
        chm_pkg::ST_HASH: begin
          bucket_nxt = hash_top >> hb_shift;
          state_nxt  = chm_pkg::ST_RDB;
        end
        chm_pkg::ST_RDB: begin
          state_nxt = chm_pkg::ST_CHKB;
        end
        chm_pkg::ST_CHKB: begin
          used_nxt     = meta_rdata[META_W-1];
          len_nxt      = meta_rdata[LEN_W-1:0];
          mkey_nxt     = main_rdata[ENTRY_W-1 -: 64];
          mitem_nxt    = main_rdata[ITEM_BITS-1:0];
          pos_main_nxt = 1'b1;
          idx_nxt      = '0;
          if (!meta_rdata[META_W-1]) begin
            found_nxt = 1'b0;
            state_nxt = chm_pkg::ST_ACT;
          end else if (main_rdata[ENTRY_W-1 -: 64] == key_r) begin
            found_nxt = 1'b1;
            state_nxt = chm_pkg::ST_ACT;
          end else if (meta_rdata[LEN_W-1:0] == '0) begin
            found_nxt = 1'b0;
            state_nxt = chm_pkg::ST_ACT;
          end else begin
            pos_main_nxt = 1'b0;
            state_nxt    = chm_pkg::ST_SCAN;
          end
        end
        chm_pkg::ST_SCAN: begin
          state_nxt = chm_pkg::ST_SCHK;
        end
        chm_pkg::ST_SCHK: begin
          ckey_nxt  = chain_rdata[ENTRY_W-1 -: 64];
          citem_nxt = chain_rdata[ITEM_BITS-1:0];
          if (chain_rdata[ENTRY_W-1 -: 64] == key_r) begin
            found_nxt = 1'b1;
            state_nxt = chm_pkg::ST_ACT;
          end else if (idx_r + 1'b1 == len_r) begin
            found_nxt = 1'b0;
            state_nxt = chm_pkg::ST_ACT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = chm_pkg::ST_SCAN;
          end
        end
        chm_pkg::ST_ACT: begin
          unique case (op_r)
            chm_pkg::OP_LOOKUP: begin
              if (found_r) begin
                item_out_nxt = found_item64[chm_pkg::ITEM_IO_W-1:0];
              end
              tail_nxt = chm_pkg::TL_FIN;
            end
            chm_pkg::OP_REPLACE: begin
              if (found_r && pos_main_r) begin
                main_we    = 1'b1;
                main_wdata = {mkey_r, item_r};
              end else if (found_r) begin
                chain_we    = 1'b1;
                chain_wdata = {ckey_r, item_r};
              end
              tail_nxt = chm_pkg::TL_FIN;
            end
            chm_pkg::OP_INSERT, chm_pkg::OP_REMOVE: begin
              if (found_r) begin
                if (ent_r != '0) begin
                  ent_nxt = ent_r - 1'b1;
                end
                if (pos_main_r && len_r == '0) begin
                  used_nxt = 1'b0;
                  if (op_r == chm_pkg::OP_INSERT) begin
                    state_nxt = chm_pkg::ST_ADD;
                  end else begin
                    tail_nxt = chm_pkg::TL_FIN;
                  end
                end else if (pos_main_r) begin
                  // Promote chain entry 0 into the main slot, then close the gap.
                  idx_nxt   = '0;
                  state_nxt = chm_pkg::ST_PRD;
                end else begin
                  state_nxt = chm_pkg::ST_SHIFT;
                end
              end else if (op_r == chm_pkg::OP_INSERT) begin
                state_nxt = chm_pkg::ST_ADD;
              end else begin
                tail_nxt = chm_pkg::TL_FIN;
              end
            end
            default: begin
              tail_nxt = chm_pkg::TL_FIN;
            end
          endcase
        end
        chm_pkg::ST_PRD: begin
          chain_ridx = '0;
          state_nxt  = chm_pkg::ST_PWR;
        end
        chm_pkg::ST_PWR: begin
          main_we    = 1'b1;
          main_wdata = chain_rdata;
          state_nxt  = chm_pkg::ST_SHIFT;
        end
        chm_pkg::ST_SHIFT: begin
          if (idx_r + 1'b1 < len_r) begin
            chain_ridx = IDX_W'(idx_r + 1'b1);
            state_nxt  = chm_pkg::ST_SWR;
          end else begin
            len_nxt = len_r - 1'b1;
            if (len_r == LEN_W'(1) && chained_r != '0) begin
              chained_nxt = chained_r - 1'b1;
            end
            if (op_r == chm_pkg::OP_INSERT) begin
              state_nxt = chm_pkg::ST_ADD;
            end else begin
              tail_nxt = chm_pkg::TL_FIN;
            end
          end
        end
        chm_pkg::ST_SWR: begin
          chain_we    = 1'b1;
          chain_wdata = chain_rdata;
          idx_nxt     = idx_r + 1'b1;
          state_nxt   = chm_pkg::ST_SHIFT;
        end
        chm_pkg::ST_ADD: begin
          // Also parks here for an unused opcode while tail_r finishes it.
          if (op_r == chm_pkg::OP_INSERT) begin
            if (!used_r) begin
              main_we  = 1'b1;
              used_nxt = 1'b1;
              ent_nxt  = ent_r + 1'b1;
            end else if (len_r < LEN_W'(CHAIN_DEPTH)) begin
              chain_we   = 1'b1;
              chain_widx = len_r[IDX_W-1:0];
              len_nxt    = len_r + 1'b1;
              ent_nxt    = ent_r + 1'b1;
              if (len_r == '0) begin
                chained_nxt = chained_r + 1'b1;
              end
            end else begin
              status_nxt = 1'b1;
            end
            tail_nxt = chm_pkg::TL_FIN;
          end
        end
        default: begin
          state_nxt = chm_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != chm_pkg::ST_IDLE) || (tail_r != chm_pkg::TL_NONE);
  assign out_valid = (tail_r == chm_pkg::TL_DONE);

  always_comb begin
    out_data.found           = found_r;
    out_data.item_out        = item_out_r;
    out_data.status          = status_r;
    out_data.item_count      = ent_r;
    out_data.collision_count = chained_r;
  end

`ifndef NO_ASSERTIONS
  // Every result ends the transaction: the engine is free in the next cycle.
  a_done_frees : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("engine still busy after a result");

  // A chain can never grow beyond its depth.
  a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == chm_pkg::ST_ADD || state_r == chm_pkg::ST_SHIFT) |-> len_r <= LEN_W'(CHAIN_DEPTH))
    else $error("chain length out of range");

  // A dropped insert never hit an existing key: its removal would have made room.
  a_drop_not_found : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status) |-> !out_data.found)
    else $error("chain-full status on a key that was present");

  // The item counter moves by at most one per cycle outside a clear.
  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(start) && $past(rst_n)) |->
      (ent_r == $past(ent_r) || ent_r == $past(ent_r) + 1'b1 || ent_r == $past(ent_r) - 1'b1))
    else $error("item counter jumped");
`endif

endmodule

// ----- tb/tb_chained_hash_map_engine.sv -----
// Self-checking testbench for chained_hash_map_engine: a scoreboard class predicts
// every result from its own copy of the map, and plain tasks drive the block.
// Depends on chm_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

// Scoreboard: holds a mirror of the hash map and the queue of expected
// results. The map mirror is updated when a transaction is accepted, so the
// expectation is ready before the block shows its result.
class chm_scoreboard;
  localparam int BUCKETS = 1 << chm_pkg::MAX_HASH_BITS_DEF;
  localparam int DEPTH   = chm_pkg::CHAIN_DEPTH_DEF;

  bit             main_used [BUCKETS];
  logic [63:0]    main_key  [BUCKETS];
  logic [31:0]    main_item [BUCKETS];
  int             chain_len [BUCKETS];
  logic [63:0]    chain_key [BUCKETS][DEPTH];
  logic [31:0]    chain_item[BUCKETS][DEPTH];
  int             stored;
  int             chained;
  logic [63:0]    mult;
  logic [3:0]     hbits;
  chm_pkg::out_t  expected_q[$];
  int             failures;
  int             results_seen;
  int             full_drops;

  function new();
    mult     = chm_pkg::DEF_MULT;
    hbits    = chm_pkg::DEF_HASH_BITS;
    failures = 0;
    empty_map();
  endfunction

  function void empty_map();
    foreach (main_used[b]) begin
      main_used[b] = 0;
      chain_len[b] = 0;
    end
    stored  = 0;
    chained = 0;
  endfunction

  function void set_reg(logic [chm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
    if (idx == chm_pkg::CFG_MULT) mult = value;
    else hbits = value[3:0];
  endfunction

  // Top bits of the 64-bit product; the width is clamped to the legal range.
  function int bucket_of(logic [63:0] key);
    logic [63:0] prod;
    int          hb;
    prod = mult * key;
    hb   = hbits;
    if (hb < chm_pkg::MIN_HASH_BITS) hb = chm_pkg::MIN_HASH_BITS;
    if (hb > chm_pkg::MAX_HASH_BITS_DEF) hb = chm_pkg::MAX_HASH_BITS_DEF;
    return int'(prod >> (64 - hb));
  endfunction

  // 0 for the main slot, 1+i for chain entry i, -1 when the key is absent.
  function int position_of(int b, logic [63:0] key);
    if (!main_used[b]) return -1;
    if (main_key[b] == key) return 0;
    for (int i = 0; i < chain_len[b]; i++)
      if (chain_key[b][i] == key) return i + 1;
    return -1;
  endfunction

  function void chain_shift_out(int b, int i);
    for (int j = i; j + 1 < chain_len[b]; j++) begin
      chain_key[b][j]  = chain_key[b][j+1];
      chain_item[b][j] = chain_item[b][j+1];
    end
    chain_len[b]--;
    if (chain_len[b] == 0 && chained > 0) chained--;
  endfunction

  function void take_out(int b, int pos);
    if (stored > 0) stored--;
    if (pos > 0) chain_shift_out(b, pos - 1);
    else if (chain_len[b] == 0) main_used[b] = 0;
    else begin
      // The first chain entry is promoted into the main slot.
      main_key[b]  = chain_key[b][0];
      main_item[b] = chain_item[b][0];
      chain_shift_out(b, 0);
    end
  endfunction

  function void note_op(chm_pkg::in_t t);
    chm_pkg::out_t e;
    int            b;
    int            pos;
    b   = bucket_of(t.key);
    pos = position_of(b, t.key);
    e   = '0;
    if (t.opcode <= chm_pkg::OP_REPLACE) e.found = (pos >= 0);
    case (t.opcode)
      chm_pkg::OP_INSERT: begin
        if (pos >= 0) take_out(b, pos);
        if (!main_used[b]) begin
          main_used[b] = 1;
          main_key[b]  = t.key;
          main_item[b] = t.item_in;
          stored++;
        end else if (chain_len[b] < DEPTH) begin
          if (chain_len[b] == 0) chained++;
          chain_key[b][chain_len[b]]  = t.key;
          chain_item[b][chain_len[b]] = t.item_in;
          chain_len[b]++;
          stored++;
        end else begin
          e.status = 1'b1;
          full_drops++;
        end
      end
      chm_pkg::OP_REMOVE: if (pos >= 0) take_out(b, pos);
      chm_pkg::OP_LOOKUP: begin
        if (pos == 0) e.item_out = main_item[b];
        else if (pos > 0) e.item_out = chain_item[b][pos-1];
      end
      chm_pkg::OP_REPLACE: begin
        if (pos == 0) main_item[b] = t.item_in;
        else if (pos > 0) chain_item[b][pos-1] = t.item_in;
      end
      chm_pkg::OP_CLEAR: empty_map();
      default: ;
    endcase
    e.item_count      = chm_pkg::COUNT_W'(stored);
    e.collision_count = chm_pkg::COLL_W'(chained);
    expected_q.push_back(e);
  endfunction

  function void check_result(chm_pkg::out_t got);
    chm_pkg::out_t e;
    results_seen++;
    if (expected_q.size() == 0) begin
      failures++;
      if (failures <= 10) $display("ERROR: result with nothing expected: %p", got);
      return;
    end
    e = expected_q.pop_front();
    if (got.found !== e.found || got.item_out !== e.item_out ||
        got.status !== e.status || got.item_count !== e.item_count ||
        got.collision_count !== e.collision_count) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: result %0d mismatch\n  expected %p\n  actual   %p",
                 results_seen, e, got);
    end
  endfunction
endclass

module tb_chained_hash_map_engine;

  // Cycles without any handshake on either side before the run is declared hung.
  // The limit lies well above a clear or reset sweep, the longest operation
  // and the longest idle of the sender.
  localparam int WATCHDOG_LIMIT = 20000;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  chm_pkg::in_t                   in_data;
  logic                           out_valid;
  chm_pkg::out_t                  out_data;
  logic                           cfg_we;
  logic [chm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [chm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  chm_scoreboard map_sb;
  logic [63:0]   key_pool[$];
  bit            sender_idles;
  int            stall_cycles;
  int            ops_sent;

  chained_hash_map_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Results cannot be held off, so every strobe is checked at the edge that
  // ends its cycle. Signals are read before the edge's updates take effect.
  always @(posedge clk) begin
    if (rst_n && out_valid) map_sb.check_result(out_data);
  end

  // Watchdog: any handshake on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one transaction and returns at the edge that accepts it. Start
  // is left high so that back-to-back transactions need no extra edge.
  task automatic send_op(chm_pkg::in_t t);
    start   <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (busy);
    map_sb.note_op(t);
    ops_sent++;
  endtask

  task automatic maybe_idle();
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [chm_pkg::OP_W-1:0] op, logic [63:0] key,
                             logic [31:0] item);
    chm_pkg::in_t t;
    t.opcode  = op;
    t.key     = key;
    t.item_in = item;
    send_op(t);
    maybe_idle();
  endtask

  // Registers change only with the block idle and every result drained.
  task automatic write_reg(logic [chm_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (map_sb.expected_q.size() != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    map_sb.set_reg(idx, value);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Many pool keys share their top bits so that, with a multiplier of one,
  // buckets fill up to full chains.
  function automatic void build_pool(int n);
    logic [63:0] k;
    key_pool.delete();
    for (int i = 0; i < n; i++) begin
      k = rand64();
      if ($urandom_range(0, 1)) k[63:58] = 6'($urandom_range(0, 3));
      key_pool.push_back(k);
    end
  endfunction

  task automatic random_ops(int n);
    logic [63:0]              key;
    logic [chm_pkg::OP_W-1:0] op;
    int                       r;
    for (int i = 0; i < n; i++) begin
      key = ($urandom_range(0, 9) == 0) ? rand64()
                                         : key_pool[$urandom_range(0, key_pool.size() - 1)];
      r = $urandom_range(0, 199);
      if (r < 80) op = chm_pkg::OP_INSERT;
      else if (r < 110) op = chm_pkg::OP_REMOVE;
      else if (r < 160) op = chm_pkg::OP_LOOKUP;
      else if (r < 188) op = chm_pkg::OP_REPLACE;
      else if (r < 190) op = chm_pkg::OP_CLEAR;
      else op = chm_pkg::OP_W'($urandom_range(int'(chm_pkg::OP_CLEAR) + 1,
                                              (1 << chm_pkg::OP_W) - 1));
      send_fields(op, key, $urandom());
    end
  endtask

  initial begin
    logic [63:0] base;
    map_sb       = new();
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    stall_cycles = 0;
    ops_sent     = 0;
    sender_idles = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings: field extremes, every operation
    // but clear, absent keys, re-insert of a present key and unused opcodes.
    send_fields(chm_pkg::OP_LOOKUP, 64'd0, 32'd0);
    send_fields(chm_pkg::OP_INSERT, 64'd0, 32'd0);
    send_fields(chm_pkg::OP_INSERT, '1, '1);
    send_fields(chm_pkg::OP_LOOKUP, '1, 32'd0);
    send_fields(chm_pkg::OP_INSERT, '1, 32'h5A5A_A5A5);
    send_fields(chm_pkg::OP_REPLACE, 64'd0, 32'hFFFF_0000);
    send_fields(chm_pkg::OP_LOOKUP, 64'd0, 32'd0);
    send_fields(chm_pkg::OP_REPLACE, 64'd77, 32'h1234);
    send_fields(chm_pkg::OP_REMOVE, 64'd77, 32'd0);
    send_fields(chm_pkg::OP_REMOVE, '1, 32'd0);
    for (int u = int'(chm_pkg::OP_CLEAR) + 1; u < (1 << chm_pkg::OP_W); u++)
      send_fields(chm_pkg::OP_W'(u), (u % 2 == 1) ? '1 : 64'd0, (u == 6) ? 32'd0 : '1);

    // With a multiplier of one the bucket is the key's top bits, so six keys
    // with equal top bits fill the main slot, the whole chain, and overflow.
    write_reg(chm_pkg::CFG_MULT, 64'd1);
    base = rand64();
    for (int i = 0; i < 6; i++)
      send_fields(chm_pkg::OP_INSERT, {6'h2A, base[57:3], 3'(i)}, $urandom());
    send_fields(chm_pkg::OP_REMOVE, {6'h2A, base[57:3], 3'd0}, 32'd0);
    send_fields(chm_pkg::OP_REMOVE, {6'h2A, base[57:3], 3'd2}, 32'd0);
    send_fields(chm_pkg::OP_LOOKUP, {6'h2A, base[57:3], 3'd4}, 32'd0);
    send_fields(chm_pkg::OP_INSERT, {6'h2A, base[57:3], 3'd1}, 32'hCAFE);
    send_fields(chm_pkg::OP_CLEAR, 64'd0, 32'd0);

    // Random phases, each under its own settings. Some width changes leave
    // the stored entries in place, and out-of-range widths are included.
    build_pool(150);
    random_ops(130);
    write_reg(chm_pkg::CFG_HBITS, {$urandom(), 28'd0, 4'd0});
    random_ops(120);
    write_reg(chm_pkg::CFG_MULT, '1);
    write_reg(chm_pkg::CFG_HBITS, 64'd10);
    build_pool(250);
    random_ops(130);
    write_reg(chm_pkg::CFG_HBITS, {rand64()} | 64'hF);
    random_ops(120);
    write_reg(chm_pkg::CFG_MULT, rand64() | 64'd1);
    write_reg(chm_pkg::CFG_HBITS, 64'd8);
    build_pool(120);
    random_ops(130);
    write_reg(chm_pkg::CFG_MULT, chm_pkg::DEF_MULT);
    write_reg(chm_pkg::CFG_HBITS, 64'd6);
    build_pool(200);
    random_ops(130);
    sender_idles = 1'b0;
    write_reg(chm_pkg::CFG_MULT, 64'd1);
    build_pool(100);
    random_ops(170);

    start <= 1'b0;
    while (map_sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    map_sb.failures += map_sb.expected_q.size();
    $display("Ran %0d operations across several register settings; %0d inserts hit a full chain.",
             ops_sent, map_sb.full_drops);
    $display("Checked %0d results, %0d failures.", map_sb.results_seen, map_sb.failures);
    if (map_sb.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
